/* rtl/core/histogram_percentile_highlight_macros.svh */
// ---------------------------------------------------------------------------
// Assertion macros for the histogram percentile highlight block
// Shorthand for clocked implication checks, all disabled during reset.
// ---------------------------------------------------------------------------
`ifndef HISTOGRAM_PERCENTILE_HIGHLIGHT_MACROS_SVH
`define HISTOGRAM_PERCENTILE_HIGHLIGHT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define HPH_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define HPH_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/hph_pkg.sv */
// ---------------------------------------------------------------------------
// hph_pkg
// Shared types and constants of the histogram percentile highlight block.
// ---------------------------------------------------------------------------
package hph_pkg;

  localparam int PIXEL_W            = 8;
  localparam int NUM_BINS           = 256;
  localparam int BIN_AW             = 8;
  localparam int PROP_W             = 11;
  localparam int Q10_SHIFT          = 10;
  localparam int MAX_PIXELS_DEFAULT = 1024;

  localparam logic [PROP_W-1:0]  PROP_RESET      = 11'd102;
  localparam logic [PIXEL_W-1:0] HIGHLIGHT_RESET = 8'd200;

  // Configuration port.
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 11;
  localparam logic [CFG_IDX_W-1:0] REG_PROPORTION = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HIGHLIGHT  = 1'd1;

  // Input operation codes (carried on tuser).
  localparam logic OP_ACCUMULATE = 1'b0;
  localparam logic OP_APPLY      = 1'b1;

  // Output kinds (carried on tuser).
  localparam logic KIND_REPORT = 1'b0;
  localparam logic KIND_PIXEL  = 1'b1;

  localparam int OUT_DATA_W = 2 * PIXEL_W;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ACC_WR,
    ST_PREP,
    ST_WALK,
    ST_REPORT
  } state_t;

  typedef struct packed {
    logic acc_rd;   // read the bin of the accepted pixel
    logic acc_wr;   // write back the incremented bin
    logic prep;     // form the target and restart the walk
    logic walk;     // walk the bins from the top
    logic report;   // load the threshold report into the output register
    logic apply;    // map the accepted pixel into the output register
  } cmd_t;

  typedef struct packed {
    logic acc_last; // the pixel in flight closes the accumulate pass
    logic hit;      // the walk has found its bin this cycle
    logic out_free; // the output register can take a new beat
  } status_t;

endpackage

/* rtl/core/histogram_percentile_highlight.sv */
// Apply beats: one beat per cycle while the output is taken, the mapped pixel appears in the cycle after acceptance.
// Accumulate beats: each is a read-modify-write of the histogram RAM; input is held off during the write-back.
// Last accumulate beat: the walk reads one bin per cycle from 255 down, and input is
// held off until the threshold report is loaded into the output register.
// Reset (rst, synchronous, active high) clears the histogram valid bits, count,
// threshold and output, and restores proportion 102 and highlight value 200.
// ---------------------------------------------------------------------------
// histogram_percentile_highlight
// Histogram of a grey image, percentile threshold, and highlighting of
// the pixels above it.
// ---------------------------------------------------------------------------
//
// An accumulate beat bumps its pixel's bin and the pixel count, until the
// count reaches MAX_PIXELS; further pixels are dropped, though a last mark
// still ends the pass. On the last accumulate beat the controller walks the
// bins from the top, keeping a running sum, and stops at the first bin where
// 1024 times the sum reaches proportion times count (or at bin zero). The
// threshold is one below that bin, clamped at zero. A report beat carries it,
// and the histogram is emptied by clearing all its valid bits together.
//
// An apply beat passes its pixel through unless it exceeds the threshold,
// in which case the highlight value replaces it.
//
// The controller (hph_ctrl) sequences the work; the datapath (hph_datapath)
// holds the histogram RAM, the walk arithmetic and the output register.
module histogram_percentile_highlight #(
  parameter int MAX_PIXELS = hph_pkg::MAX_PIXELS_DEFAULT
) (
  input  logic                           clk,
  input  logic                           rst,
  // Input stream.
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [hph_pkg::PIXEL_W-1:0]    s_axis_tdata,  // [7:0] pixel
  input  logic                           s_axis_tuser,  // [0] operation
  input  logic                           s_axis_tlast,  // last pixel of pass
  // Output stream.
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [hph_pkg::OUT_DATA_W-1:0] m_axis_tdata,  // [7:0] pixel_out,
                                                        // [15:8] threshold_value
  output logic                           m_axis_tuser,  // [0] output_kind
  // Configuration writes.
  input  logic                           cfg_we,
  input  logic [hph_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [hph_pkg::CFG_DATA_W-1:0] cfg_data
);

  hph_pkg::cmd_t    cmd;
  hph_pkg::status_t status;

  hph_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_op    (s_axis_tuser),
    .in_ready (s_axis_tready),
    .status   (status),
    .cmd      (cmd)
  );

  hph_datapath #(
    .MAX_PIXELS (MAX_PIXELS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .in_pixel  (s_axis_tdata),
    .in_last   (s_axis_tlast),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (m_axis_tdata),
    .out_kind  (m_axis_tuser)
  );

`include "histogram_percentile_highlight_macros.svh"

  // An accepted apply beat always yields an output beat in the next cycle.
  `HPH_ASSERT_NEXT(a_apply_result, s_axis_tvalid && s_axis_tready && s_axis_tuser, m_axis_tvalid && m_axis_tuser, "apply beat without result")

  // Input is only taken when the output register can take a result.
  `HPH_ASSERT_SAME(a_ready_needs_room, s_axis_tready, !m_axis_tvalid || m_axis_tready, "input taken with output blocked")

  // A threshold report carries a zero pixel field.
  `HPH_ASSERT_SAME(a_report_pixel_zero, m_axis_tvalid && !m_axis_tuser, m_axis_tdata[7:0] == 8'd0, "report with nonzero pixel")

  // A walk hit never happens while the controller prepares the walk.
  `HPH_ASSERT_SAME(a_hit_in_walk, status.hit && !cmd.walk, !cmd.prep, "walk hit during preparation")

endmodule

/* rtl/core/hph_ram.sv */
// ---------------------------------------------------------------------------
// hph_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ---------------------------------------------------------------------------
module hph_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/core/hph_ctrl.sv */
// ---------------------------------------------------------------------------
// hph_ctrl
// Sequencer: accepts beats, steps the histogram update, walk and report.
// ---------------------------------------------------------------------------
module hph_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              in_op,
  output logic              in_ready,
  input  hph_pkg::status_t  status,
  output hph_pkg::cmd_t     cmd
);

  hph_pkg::state_t state;
  hph_pkg::state_t state_next;
  logic            accept;

  assign in_ready = (state == hph_pkg::ST_IDLE) && status.out_free;
  assign accept   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= hph_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      hph_pkg::ST_IDLE: begin
        if (accept && (in_op == hph_pkg::OP_ACCUMULATE)) begin
          state_next = hph_pkg::ST_ACC_WR;
        end
      end
      hph_pkg::ST_ACC_WR: begin
        state_next = status.acc_last ? hph_pkg::ST_PREP : hph_pkg::ST_IDLE;
      end
      hph_pkg::ST_PREP: begin
        state_next = hph_pkg::ST_WALK;
      end
      hph_pkg::ST_WALK: begin
        if (status.hit) begin
          state_next = hph_pkg::ST_REPORT;
        end
      end
      hph_pkg::ST_REPORT: begin
        if (status.out_free) begin
          state_next = hph_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = hph_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd = '0;
    case (state)
      hph_pkg::ST_IDLE: begin
        cmd.acc_rd = accept && (in_op == hph_pkg::OP_ACCUMULATE);
        cmd.apply  = accept && (in_op == hph_pkg::OP_APPLY);
      end
      hph_pkg::ST_ACC_WR: begin
        cmd.acc_wr = 1'b1;
      end
      hph_pkg::ST_PREP: begin
        cmd.prep = 1'b1;
      end
      hph_pkg::ST_WALK: begin
        cmd.walk = 1'b1;
      end
      hph_pkg::ST_REPORT: begin
        cmd.report = status.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

/* rtl/core/hph_datapath.sv */
// ---------------------------------------------------------------------------
// hph_datapath
// Histogram storage, pixel count, percentile walk, threshold and output.
// ---------------------------------------------------------------------------
module hph_datapath #(
  parameter int MAX_PIXELS = hph_pkg::MAX_PIXELS_DEFAULT
) (
  input  logic                              clk,
  input  logic                              rst,
  input  hph_pkg::cmd_t                     cmd,
  output hph_pkg::status_t                  status,
  input  logic [hph_pkg::PIXEL_W-1:0]       in_pixel,
  input  logic                              in_last,
  input  logic                              cfg_we,
  input  logic [hph_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [hph_pkg::CFG_DATA_W-1:0]    cfg_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [hph_pkg::OUT_DATA_W-1:0]    out_data,
  output logic                              out_kind
);

  // A bin never holds more than the pixel count, which stops at MAX_PIXELS.
  localparam int CW = $clog2(MAX_PIXELS + 1);
  localparam int TW = CW + hph_pkg::PROP_W;
  localparam logic [CW-1:0] MAX_COUNT = CW'(MAX_PIXELS);

  // Configuration registers.
  logic [hph_pkg::PROP_W-1:0]  proportion;
  logic [hph_pkg::PIXEL_W-1:0] highlight;

  always_ff @(posedge clk) begin
    if (rst) begin
      proportion <= hph_pkg::PROP_RESET;
      highlight  <= hph_pkg::HIGHLIGHT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        hph_pkg::REG_PROPORTION: proportion <= cfg_data;
        hph_pkg::REG_HIGHLIGHT:  highlight  <= cfg_data[hph_pkg::PIXEL_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Histogram memory with one valid bit per bin; an invalid bin reads as zero.
  logic [hph_pkg::NUM_BINS-1:0] bin_valid;
  logic                         ram_we;
  logic                         ram_re;
  logic [hph_pkg::BIN_AW-1:0]   ram_raddr;
  logic [CW-1:0]                ram_wdata;
  logic [CW-1:0]                ram_rdata;

  // Pixel in flight through the read-modify-write.
  logic [hph_pkg::BIN_AW-1:0] acc_pix;
  logic                       acc_last;
  logic                       acc_en;
  logic [CW-1:0]              pixel_count;
  logic [CW-1:0]              acc_bin;

  // Walk state.
  logic [TW-1:0]              target;
  logic [CW-1:0]              cum;
  logic [CW-1:0]              cum_sum;
  logic [TW-1:0]              cum_scaled;
  logic [CW-1:0]              walk_bin;
  logic [hph_pkg::BIN_AW-1:0] walk_addr;
  logic                       issued_all;
  logic                       rd_v;
  logic [hph_pkg::BIN_AW-1:0] rd_bin;
  logic                       walk_issue;
  logic                       hit;
  logic [hph_pkg::PIXEL_W-1:0] threshold;

  assign walk_issue = cmd.walk && !issued_all;
  assign ram_re     = cmd.acc_rd || walk_issue;
  assign ram_raddr  = cmd.acc_rd ? in_pixel : walk_addr;
  assign ram_we     = cmd.acc_wr && acc_en;
  assign acc_bin    = bin_valid[acc_pix] ? ram_rdata : '0;
  assign ram_wdata  = acc_bin + CW'(1);

  hph_ram #(
    .WIDTH (CW),
    .DEPTH (hph_pkg::NUM_BINS)
  ) u_hist_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (acc_pix),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (cmd.acc_rd) begin
      acc_pix  <= in_pixel;
      acc_last <= in_last;
      acc_en   <= (pixel_count < MAX_COUNT);
    end
  end

  // Bin sum so far, scaled by 1024, against proportion times count.
  assign walk_bin   = bin_valid[rd_bin] ? ram_rdata : '0;
  assign cum_sum    = cum + walk_bin;
  assign cum_scaled = TW'({cum_sum, {hph_pkg::Q10_SHIFT{1'b0}}});
  assign hit        = rd_v && ((cum_scaled >= target) || (rd_bin == '0));

  always_ff @(posedge clk) begin
    if (cmd.prep) begin
      target <= TW'(proportion) * TW'(pixel_count);
    end
    if (cmd.prep) begin
      cum <= '0;
    end else if (cmd.walk && rd_v) begin
      cum <= cum_sum;
    end
    if (walk_issue) begin
      rd_bin <= walk_addr;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bin_valid   <= '0;
      pixel_count <= '0;
      threshold   <= '0;
      walk_addr   <= '1;
      issued_all  <= 1'b0;
      rd_v        <= 1'b0;
    end else begin
      rd_v <= walk_issue;
      if (cmd.prep) begin
        walk_addr  <= '1;
        issued_all <= 1'b0;
      end else if (walk_issue) begin
        walk_addr  <= walk_addr - hph_pkg::BIN_AW'(1);
        issued_all <= (walk_addr == '0);
      end
      if (cmd.walk && hit) begin
        // The threshold sits one below the stopping bin, clamped at zero.
        threshold   <= (rd_bin == '0) ? '0 : rd_bin - hph_pkg::BIN_AW'(1);
        bin_valid   <= '0;
        pixel_count <= '0;
      end else if (ram_we) begin
        bin_valid[acc_pix] <= 1'b1;
        pixel_count        <= pixel_count + CW'(1);
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.apply || cmd.report) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.apply) begin
      out_kind <= hph_pkg::KIND_PIXEL;
      out_data <= {threshold, (in_pixel > threshold) ? highlight : in_pixel};
    end else if (cmd.report) begin
      out_kind <= hph_pkg::KIND_REPORT;
      out_data <= {threshold, {hph_pkg::PIXEL_W{1'b0}}};
    end
  end

  assign status.acc_last = acc_last;
  assign status.hit      = hit;
  assign status.out_free = !out_valid || out_ready;

endmodule

/* dv/testbench.sv */
// ---------------------------------------------------------------------------
// Testbench for histogram_percentile_highlight
// Streams accumulate and apply beats through the block under random valid
// and ready gaps, predicts every report and mapped pixel with its own model
// of the histogram walk, and compares each output beat field by field.
// ---------------------------------------------------------------------------
module testbench;
  import hph_pkg::*;

  localparam int MAX_PIXELS   = MAX_PIXELS_DEFAULT;
  localparam int Q10_ONE      = 1 << Q10_SHIFT;
  // Beats of the random part, the full-image pass included.
  localparam int RANDOM_ITEMS = 1450;
  // This pause lets the walk after a last beat run out before any register
  // write or the final verdict.
  localparam int IDLE_PAD     = 300;
  // Bound on how long a drain may take before leftovers are declared.
  localparam int DRAIN_LIMIT  = 20000;
  localparam int N_DIR        = 26;

  // One output beat as the block reports it.
  typedef struct packed {
    logic                 kind;
    logic [PIXEL_W-1:0]   pixel_out;
    logic [PIXEL_W-1:0]   threshold;
  } result_t;

  typedef enum logic {ROW_BEAT, ROW_WRITE} row_kind_t;

  // One row of the directed table. A write row uses index and value; a beat
  // row uses op, pixel and last, and carries a typed-in result when typed.
  typedef struct packed {
    row_kind_t            kind;
    logic                 op;
    logic [PIXEL_W-1:0]   pixel;
    logic                 last;
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_DATA_W-1:0] value;
    logic                 typed;
    result_t              want;
  } stim_row_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [PIXEL_W-1:0]    s_axis_tdata = '0;
  logic                  s_axis_tuser = OP_ACCUMULATE;
  logic                  s_axis_tlast = 1'b0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  m_axis_tuser;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = REG_PROPORTION;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // While set, neither side inserts idle cycles.
  bit quiet = 1'b0;
  int mismatches = 0;

  // Shadow copy of the block's state and registers.
  logic [10:0]           hist_bins [NUM_BINS];
  logic [10:0]           hist_count = '0;
  logic [PIXEL_W-1:0]    thr_held = '0;
  logic [PROP_W-1:0]     prop_q10 = PROP_RESET;
  logic [PIXEL_W-1:0]    highlight = HIGHLIGHT_RESET;

  // Results owed by the block, oldest first.
  result_t pending_results [$];

  histogram_percentile_highlight #(
    .MAX_PIXELS(MAX_PIXELS)
  ) u_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),   // [7:0] pixel
    .s_axis_tuser  (s_axis_tuser),   // [0] operation
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),   // [7:0] pixel_out, [15:8] threshold_value
    .m_axis_tuser  (m_axis_tuser),   // [0] output_kind
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // The whole run must fit well inside this; a hang ends here.
  initial begin
    #5_000_000;
    $display("FAILURE");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    mismatches++;
  endtask

  task automatic check_field(input string name, input int got, input int want);
    if (got != want) begin
      report_mismatch($sformatf("%s is %0d, expected %0d", name, got, want));
    end
  endtask

  // Advances the shadow model by one accepted input beat. Returns 1 and the
  // expected output beat when the input beat causes one.
  function automatic bit histogram_step(input logic op, input logic [PIXEL_W-1:0] pix,
                                        input logic last, output result_t res);
    int unsigned target;
    int unsigned cum;
    int          b;
    bit          found;
    res = '0;
    // An apply beat maps the pixel against the threshold held right now.
    if (op == OP_APPLY) begin
      res.kind      = KIND_PIXEL;
      res.pixel_out = (pix > thr_held) ? highlight : pix;
      res.threshold = thr_held;
      return 1'b1;
    end
    // Once the count is saturated, further pixels are dropped, but a last
    // mark on one of them still closes the pass.
    if (hist_count < MAX_PIXELS) begin
      hist_bins[pix] = hist_bins[pix] + 1'b1;
      hist_count     = hist_count + 1'b1;
    end
    if (!last) return 1'b0;
    // Walk from the top bin down. The top bin is always summed before the
    // first test, so a zero proportion stops right there. A proportion above
    // one may never be met, and then the walk runs out at bin zero.
    target = prop_q10 * hist_count;
    cum    = 0;
    found  = 1'b0;
    thr_held = '0;
    for (b = NUM_BINS - 1; b >= 0 && !found; b--) begin
      cum = cum + hist_bins[b];
      if (Q10_ONE * cum >= target) begin
        found    = 1'b1;
        thr_held = (b > 0) ? PIXEL_W'(b - 1) : '0;
      end
    end
    foreach (hist_bins[i]) hist_bins[i] = '0;
    hist_count    = '0;
    res.kind      = KIND_REPORT;
    res.pixel_out = '0;
    res.threshold = thr_held;
    return 1'b1;
  endfunction

  // Offers one input beat, possibly after a random idle gap, and returns at
  // the edge where it is taken. A typed-in result replaces the predicted one.
  task automatic send_beat(input logic op, input logic [PIXEL_W-1:0] pix, input logic last,
                           input bit typed, input result_t typed_res);
    int      gap;
    result_t res;
    bit      has_res;
    if (!quiet && $urandom_range(99) < 20) begin
      gap = $urandom_range(1, 4);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= pix;
    s_axis_tuser  <= op;
    s_axis_tlast  <= last;
    do @(posedge clk); while (!s_axis_tready);
    has_res = histogram_step(op, pix, last, res);
    if (typed) pending_results.push_back(typed_res);
    else if (has_res) pending_results.push_back(res);
  endtask

  // Waits until every owed result has come out, then lets the walk of any
  // beat that owes nothing run out as well.
  task automatic wait_idle();
    int n;
    n = 0;
    while (pending_results.size() != 0 && n < DRAIN_LIMIT) begin
      @(posedge clk);
      n++;
    end
    repeat (IDLE_PAD) @(posedge clk);
  endtask

  // Writes one register and mirrors it into the shadow model. The trailing
  // edge keeps two writes in a row from landing in the same step.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    if (idx == REG_PROPORTION) prop_q10 = val;
    else highlight = val[PIXEL_W-1:0];
  endtask

  // The receiver stalls about one cycle in five, except in quiet stretches.
  always @(posedge clk) begin
    m_axis_tready <= quiet || ($urandom_range(99) >= 20);
  end

  // Every output beat taken must match the oldest owed result.
  always @(posedge clk) begin : out_monitor
    result_t got;
    result_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = {m_axis_tuser, m_axis_tdata[7:0], m_axis_tdata[15:8]};
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("output beat %h with nothing owed", got));
      end else begin
        want = pending_results.pop_front();
        check_field("output_kind", got.kind, want.kind);
        check_field("pixel_out", got.pixel_out, want.pixel_out);
        check_field("threshold_value", got.threshold, want.threshold);
      end
    end
  end

  // Directed table. After reset the threshold is zero, the proportion 102
  // and the highlight 200, so the typed-in rows follow by hand.
  stim_row_t dir_rows [N_DIR] = '{
    // Apply against the reset threshold; the last mark is ignored here.
    '{ROW_BEAT, OP_APPLY, 8'd0, 1'b0, '0, '0, 1'b1, '{KIND_PIXEL, 8'd0, 8'd0}},
    '{ROW_BEAT, OP_APPLY, 8'd255, 1'b1, '0, '0, 1'b1, '{KIND_PIXEL, 8'd200, 8'd0}},
    // A single bright pixel: the walk stops at the top bin.
    '{ROW_BEAT, OP_ACCUMULATE, 8'd255, 1'b1, '0, '0, 1'b1, '{KIND_REPORT, 8'd0, 8'd254}},
    '{ROW_BEAT, OP_APPLY, 8'd255, 1'b0, '0, '0, 1'b1, '{KIND_PIXEL, 8'd200, 8'd254}},
    '{ROW_BEAT, OP_APPLY, 8'd254, 1'b0, '0, '0, 1'b1, '{KIND_PIXEL, 8'd254, 8'd254}},
    // Zero proportion: the top bin alone satisfies the walk.
    '{ROW_WRITE, 1'b0, 8'd0, 1'b0, REG_PROPORTION, 11'd0, 1'b0, '0},
    '{ROW_WRITE, 1'b0, 8'd0, 1'b0, REG_HIGHLIGHT, 11'd255, 1'b0, '0},
    '{ROW_BEAT, OP_ACCUMULATE, 8'd0, 1'b1, '0, '0, 1'b1, '{KIND_REPORT, 8'd0, 8'd254}},
    '{ROW_BEAT, OP_APPLY, 8'd255, 1'b0, '0, '0, 1'b1, '{KIND_PIXEL, 8'd255, 8'd254}},
    // Largest proportion: never met, so the walk runs out and gives zero.
    '{ROW_WRITE, 1'b0, 8'd0, 1'b0, REG_PROPORTION, 11'd2047, 1'b0, '0},
    '{ROW_BEAT, OP_ACCUMULATE, 8'd7, 1'b0, '0, '0, 1'b0, '0},
    '{ROW_BEAT, OP_ACCUMULATE, 8'd9, 1'b1, '0, '0, 1'b1, '{KIND_REPORT, 8'd0, 8'd0}},
    '{ROW_WRITE, 1'b0, 8'd0, 1'b0, REG_HIGHLIGHT, 11'd0, 1'b0, '0},
    '{ROW_BEAT, OP_APPLY, 8'd1, 1'b0, '0, '0, 1'b1, '{KIND_PIXEL, 8'd0, 8'd0}},
    '{ROW_BEAT, OP_APPLY, 8'd0, 1'b1, '0, '0, 1'b1, '{KIND_PIXEL, 8'd0, 8'd0}},
    // Proportion of exactly one: met only at bin zero, clamped to zero.
    '{ROW_WRITE, 1'b0, 8'd0, 1'b0, REG_PROPORTION, 11'd1024, 1'b0, '0},
    '{ROW_BEAT, OP_ACCUMULATE, 8'd0, 1'b0, '0, '0, 1'b0, '0},
    '{ROW_BEAT, OP_ACCUMULATE, 8'd128, 1'b1, '0, '0, 1'b1, '{KIND_REPORT, 8'd0, 8'd0}},
    // Half of two pixels: met exactly at the brighter one.
    '{ROW_WRITE, 1'b0, 8'd0, 1'b0, REG_PROPORTION, 11'd512, 1'b0, '0},
    '{ROW_BEAT, OP_ACCUMULATE, 8'd100, 1'b0, '0, '0, 1'b0, '0},
    '{ROW_BEAT, OP_ACCUMULATE, 8'd200, 1'b1, '0, '0, 1'b1, '{KIND_REPORT, 8'd0, 8'd199}},
    '{ROW_BEAT, OP_APPLY, 8'd200, 1'b0, '0, '0, 1'b0, '0},
    '{ROW_BEAT, OP_APPLY, 8'd199, 1'b0, '0, '0, 1'b0, '0},
    '{ROW_BEAT, OP_APPLY, 8'd37, 1'b1, '0, '0, 1'b0, '0},
    '{ROW_WRITE, 1'b0, 8'd0, 1'b0, REG_PROPORTION, 11'd102, 1'b0, '0},
    '{ROW_WRITE, 1'b0, 8'd0, 1'b0, REG_HIGHLIGHT, 11'd200, 1'b0, '0}
  };

  initial begin : stimulus
    int                 phase;
    int                 random_items;
    int                 n_acc;
    int                 n_app;
    bit                 broken;
    logic [PROP_W-1:0]  prop;
    logic [PIXEL_W-1:0] hl;
    logic [PIXEL_W-1:0] base;
    logic [PIXEL_W-1:0] spread;
    logic [PIXEL_W-1:0] pix;

    foreach (hist_bins[i]) hist_bins[i] = '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[r]) begin
      if (dir_rows[r].kind == ROW_WRITE) begin
        s_axis_tvalid <= 1'b0;
        wait_idle();
        write_reg(dir_rows[r].index, dir_rows[r].value);
      end else begin
        send_beat(dir_rows[r].op, dir_rows[r].pixel, dir_rows[r].last,
                  dir_rows[r].typed, dir_rows[r].want);
      end
    end

    // Random images: each phase sets both registers, streams one image
    // into the histogram and then a run of apply beats. Phase 2 is a full
    // image that runs eight pixels past the saturation point, so the count
    // stops at its limit and the last mark lands on a dropped pixel.
    phase        = 0;
    random_items = 0;
    while (random_items < RANDOM_ITEMS) begin
      s_axis_tvalid <= 1'b0;
      wait_idle();
      quiet = (phase >= 3 && phase < 6);

      case ($urandom_range(0, 5))
        0:       prop = 11'd0;
        1:       prop = 11'd1024;
        2:       prop = 11'd2047;
        default: prop = PROP_W'($urandom_range(0, 1100));
      endcase
      write_reg(REG_PROPORTION, prop);
      if ($urandom_range(0, 3) == 0) hl = $urandom_range(0, 1) ? 8'd255 : 8'd0;
      else hl = PIXEL_W'($urandom_range(0, 255));
      write_reg(REG_HIGHLIGHT, {3'b0, hl});

      if (phase == 2) n_acc = MAX_PIXELS + 8;
      else n_acc = $urandom_range(1, 60);

      // Pixels cluster around a random base with a random spread, so that
      // thresholds land all over the range and not only near the middle.
      base = PIXEL_W'($urandom_range(0, 255));
      case ($urandom_range(0, 2))
        0:       spread = 8'hFF;
        1:       spread = 8'h0F;
        default: spread = 8'h01;
      endcase
      // Now and then an image ends without its last mark, so the next one
      // piles on top of it.
      broken = ($urandom_range(0, 19) == 0);

      for (int i = 0; i < n_acc; i++) begin
        if ($urandom_range(99) < 4) begin
          send_beat(OP_APPLY, PIXEL_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                    1'b0, '0);
          random_items++;
        end
        pix = base + (PIXEL_W'($urandom_range(0, 255)) & spread);
        send_beat(OP_ACCUMULATE, pix, (i == n_acc - 1) && !broken, 1'b0, '0);
      end

      // Apply pixels are aimed at the threshold half of the time, where the
      // comparison flips.
      n_app = $urandom_range(1, 50);
      for (int i = 0; i < n_app; i++) begin
        if ($urandom_range(0, 1)) pix = PIXEL_W'($urandom_range(0, 255));
        else pix = PIXEL_W'(thr_held + $urandom_range(0, 2) - 1);
        send_beat(OP_APPLY, pix, 1'($urandom_range(0, 1)), 1'b0, '0);
      end

      random_items += n_acc + n_app;
      phase++;
    end

    s_axis_tvalid <= 1'b0;
    quiet = 1'b0;
    wait_idle();
    if (pending_results.size() != 0) begin
      report_mismatch($sformatf("%0d results never came out", pending_results.size()));
    end

    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
